// ----- hw/rtl/ssmr_pkg.sv -----
// shared types and constants for the front-sector minimum range block
// no dependencies; imported by every other file of the block
`default_nettype none

package ssmr_pkg;

  localparam int RANGE_W  = 16;
  localparam int CFG_W    = 16;
  localparam int VCOUNT_W = 13;
  localparam int CFG_IDX_W = 3;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_CENTER     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_HALF_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ANGLE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_FLOOR       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_CEILING     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_DISTANCE     = 3'd6;

  // register reset values
  localparam logic [CFG_W-1:0] RST_SECTOR_CENTER     = 16'd32768;
  localparam logic [CFG_W-1:0] RST_SECTOR_HALF_WIDTH = 16'd2731;
  localparam logic [CFG_W-1:0] RST_FIRST_ANGLE       = 16'd0;
  localparam logic [CFG_W-1:0] RST_ANGLE_STEP        = 16'd182;
  localparam logic [CFG_W-1:0] RST_RANGE_FLOOR       = 16'd150;
  localparam logic [CFG_W-1:0] RST_RANGE_CEILING     = 16'd12000;
  localparam logic [CFG_W-1:0] RST_STOP_DISTANCE     = 16'd600;

  // sample kinds; any other code is skipped
  localparam logic [1:0] KIND_FINITE  = 2'd0;
  localparam logic [1:0] KIND_POS_INF = 2'd1;

  localparam logic [RANGE_W-1:0] RANGE_ALL_ONES = '1;

  typedef struct packed {
    logic [RANGE_W-1:0] sample_range_mm;
    logic [1:0]         sample_kind;
    logic               last_sample;
  } ssmr_in_t;

  typedef struct packed {
    logic [RANGE_W-1:0]  min_range_mm;
    logic                min_is_infinite;
    logic [VCOUNT_W-1:0] valid_count;
    logic                sector_empty;
    logic                obstacle;
    logic                metadata_invalid;
  } ssmr_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] sector_center;
    logic [CFG_W-1:0] sector_half_width;
    logic [CFG_W-1:0] first_angle;
    logic [CFG_W-1:0] angle_step;
    logic [CFG_W-1:0] range_floor_mm;
    logic [CFG_W-1:0] range_ceiling_mm;
    logic [CFG_W-1:0] stop_distance_mm;
  } ssmr_cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/scan_sector_min_range_core.sv -----
// top level of the front-sector minimum range block: config registers,
// input register, accumulator and result register; depends on ssmr_pkg, ssmr_accum
`default_nettype none

//  channel | ports                          | moves
//  --------+--------------------------------+-----------------------------------
//  in      | in_valid, in_stall, in_data    | one range sample request per cycle unless stalled
//  out     | out_valid, out_stall, out_data | one summary per sweep (last sample)
//  cfg     | cfg_we, cfg_index, cfg_wdata   | register write, no wait, no read
//
//  one sample request per cycle sustained unless a last sample waits on the output;
//  a sample is held in the input register, and a last sample gives its summary
//  in the result register once that register is free, which raises out_valid.
//  the accumulator loop (angle add, sector compare, min compare, count) is a
//  single combinational path from the accumulator registers back to themselves.
//  reset is synchronous; it clears the sweep state and restores register defaults.
//  in_stall rises only while a last sample waits for a stalled result register.

module scan_sector_min_range_core import ssmr_pkg::*; #(
  parameter int MAX_SAMPLES = 4096,
  parameter int ANGLE_BITS  = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire ssmr_in_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ssmr_out_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  ssmr_cfg_t cfg_r, cfg_nxt;

  // input register
  logic      s1_valid_r, s1_valid_nxt;
  ssmr_in_t  s1_data_r;
  logic      s1_adv, in_take, out_free;

  // result register
  logic      out_valid_r, out_valid_nxt;
  ssmr_out_t out_data_r;
  ssmr_out_t sweep_res;

  // ---------------- configuration registers ----------------
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SECTOR_CENTER:     cfg_nxt.sector_center     = cfg_wdata;
        REG_SECTOR_HALF_WIDTH: cfg_nxt.sector_half_width = cfg_wdata;
        REG_FIRST_ANGLE:       cfg_nxt.first_angle       = cfg_wdata;
        REG_ANGLE_STEP:        cfg_nxt.angle_step        = cfg_wdata;
        REG_RANGE_FLOOR:       cfg_nxt.range_floor_mm    = cfg_wdata;
        REG_RANGE_CEILING:     cfg_nxt.range_ceiling_mm  = cfg_wdata;
        REG_STOP_DISTANCE:     cfg_nxt.stop_distance_mm  = cfg_wdata;
        default:               cfg_nxt = cfg_r;  // unknown index ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sector_center     <= RST_SECTOR_CENTER;
      cfg_r.sector_half_width <= RST_SECTOR_HALF_WIDTH;
      cfg_r.first_angle       <= RST_FIRST_ANGLE;
      cfg_r.angle_step        <= RST_ANGLE_STEP;
      cfg_r.range_floor_mm    <= RST_RANGE_FLOOR;
      cfg_r.range_ceiling_mm  <= RST_RANGE_CEILING;
      cfg_r.stop_distance_mm  <= RST_STOP_DISTANCE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------- flow control ----------------
  // result register can take a new summary when empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  // a held sample moves on unless it is a last sample blocked at the output
  assign s1_adv   = s1_valid_r && (!s1_data_r.last_sample || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_data_r.last_sample) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (s1_adv && s1_data_r.last_sample) begin
      out_data_r <= sweep_res;
    end
  end

  // ---------------- sweep accumulator ----------------
  ssmr_accum #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .ANGLE_BITS  (ANGLE_BITS)
  ) u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_adv),
    .item   (s1_data_r),
    .cfg    (cfg_r),
    .result (sweep_res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/ssmr_accum.sv -----
// per-sweep accumulator: beam angle, sector test, running minimum and count
// depends on ssmr_pkg
`default_nettype none

module ssmr_accum import ssmr_pkg::*; #(
  parameter int MAX_SAMPLES = 4096,
  parameter int ANGLE_BITS  = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step,
  input  wire ssmr_in_t  item,
  input  wire ssmr_cfg_t cfg,
  output ssmr_out_t      result
);

  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int CFG_EXT = (ANGLE_BITS > CFG_W) ? ANGLE_BITS : CFG_W;
  localparam int VC_EXT  = (CNT_W > VCOUNT_W) ? CNT_W : VCOUNT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

  logic                  mid_sweep_r, mid_sweep_nxt;
  logic [ANGLE_BITS-1:0] beam_r, beam_nxt;
  logic [RANGE_W-1:0]    min_r, min_nxt;
  logic                  unset_r, unset_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  logic [CFG_EXT-1:0]    center_ext, first_ext, step_ext, hw_ext, mag_ext;
  logic [ANGLE_BITS-1:0] center_a, first_a, step_a;
  logic [ANGLE_BITS-1:0] beam_cur, ang_diff, mag;
  logic                  in_sec, range_ok, is_valid, set_min, bad_meta;
  logic [RANGE_W-1:0]    upd_min;
  logic                  upd_unset;
  logic [CNT_W-1:0]      upd_cnt;
  logic [VC_EXT-1:0]     vc_ext;

  // angle registers are taken modulo one turn of ANGLE_BITS
  assign center_ext = CFG_EXT'(cfg.sector_center);
  assign first_ext  = CFG_EXT'(cfg.first_angle);
  assign step_ext   = CFG_EXT'(cfg.angle_step);
  assign hw_ext     = CFG_EXT'(cfg.sector_half_width);
  assign center_a   = center_ext[ANGLE_BITS-1:0];
  assign first_a    = first_ext[ANGLE_BITS-1:0];
  assign step_a     = step_ext[ANGLE_BITS-1:0];

  assign beam_cur = mid_sweep_r ? beam_r : first_a;
  // signed wrap of the angle difference, then its magnitude
  assign ang_diff = beam_cur - center_a;
  assign mag      = ang_diff[ANGLE_BITS-1] ? (ANGLE_BITS'(0) - ang_diff) : ang_diff;
  assign mag_ext  = CFG_EXT'(mag);
  assign in_sec   = (mag_ext <= hw_ext);

  assign range_ok = (item.sample_kind == KIND_FINITE) &&
                    (item.sample_range_mm >= cfg.range_floor_mm) &&
                    (item.sample_range_mm <= cfg.range_ceiling_mm);
  assign is_valid = in_sec && (range_ok || (item.sample_kind == KIND_POS_INF));
  assign set_min  = in_sec && range_ok &&
                    (unset_r || (item.sample_range_mm < min_r));

  assign upd_min   = set_min ? item.sample_range_mm : min_r;
  assign upd_unset = unset_r && !(in_sec && range_ok);
  assign upd_cnt   = (is_valid && (cnt_r < CNT_MAX)) ? (cnt_r + 1'b1) : cnt_r;

  assign bad_meta = (step_a == '0) ||
                    (cfg.range_ceiling_mm <= cfg.range_floor_mm);
  assign vc_ext   = VC_EXT'(upd_cnt);

  always_comb begin
    if (bad_meta) begin
      result.min_range_mm     = '0;
      result.min_is_infinite  = 1'b1;
      result.valid_count      = '0;
      result.sector_empty     = 1'b1;
      result.obstacle         = 1'b0;
      result.metadata_invalid = 1'b1;
    end else begin
      result.min_range_mm     = upd_unset ? '0 : upd_min;
      result.min_is_infinite  = upd_unset;
      result.valid_count      = vc_ext[VCOUNT_W-1:0];
      result.sector_empty     = (upd_cnt == '0);
      result.obstacle         = !upd_unset && (upd_min <= cfg.stop_distance_mm);
      result.metadata_invalid = 1'b0;
    end
  end

  always_comb begin
    mid_sweep_nxt = mid_sweep_r;
    beam_nxt      = beam_r;
    min_nxt       = min_r;
    unset_nxt     = unset_r;
    cnt_nxt       = cnt_r;
    if (step) begin
      if (item.last_sample) begin
        // sweep closes, start the next one clean
        mid_sweep_nxt = 1'b0;
        beam_nxt      = '0;
        min_nxt       = RANGE_ALL_ONES;
        unset_nxt     = 1'b1;
        cnt_nxt       = '0;
      end else begin
        mid_sweep_nxt = 1'b1;
        beam_nxt      = beam_cur + step_a;
        min_nxt       = upd_min;
        unset_nxt     = upd_unset;
        cnt_nxt       = upd_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_sweep_r <= 1'b0;
      beam_r      <= '0;
      min_r       <= RANGE_ALL_ONES;
      unset_r     <= 1'b1;
      cnt_r       <= '0;
    end else begin
      mid_sweep_r <= mid_sweep_nxt;
      beam_r      <= beam_nxt;
      min_r       <= min_nxt;
      unset_r     <= unset_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ssmr_checker.sv -----
// port-level checks for scan_sector_min_range_core, attached by bind
// depends on ssmr_pkg and the top level's port names
`default_nettype none

module ssmr_checker import ssmr_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire ssmr_out_t out_data
);

  // after reset nothing is pending on either side
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output or stall active right after reset");

  // stalled summary holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled summary changed or dropped");

  // bad metadata gives the fixed summary
  a_bad_meta: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.metadata_invalid |->
      out_data.min_range_mm == '0 && out_data.min_is_infinite &&
      out_data.valid_count == '0 && out_data.sector_empty && !out_data.obstacle)
    else $error("metadata-invalid summary not in its fixed form");

  // no finite minimum means no range and no obstacle
  a_inf_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.min_is_infinite |->
      out_data.min_range_mm == '0 && !out_data.obstacle)
    else $error("infinite minimum carries a range or obstacle");

  // a finite minimum was counted, so the sector cannot be empty
  a_finite_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.min_is_infinite |-> !out_data.sector_empty)
    else $error("finite minimum with empty sector");

endmodule

bind scan_sector_min_range_core ssmr_checker u_ssmr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ----- tb/tb_scan_sector_min_range_core.sv -----
// self-checking testbench for scan_sector_min_range_core: directed and random sweeps with idle gaps
// and stalls, summaries checked against an in-bench sweep tracker
// depends on ssmr_pkg and the rtl of the block only
`default_nettype none

module tb_scan_sector_min_range_core;
  import ssmr_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int SWEEP_CAP    = 4096;     // saturation point of the valid count
  localparam int SETTLE_CYCLES = 4;       // sample register plus result register, with margin
  localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
  localparam int RANDOM_ITEMS = 700;
  localparam int LIMIT_CYCLES = 1000000;

  // codes the package leaves unnamed
  localparam logic [1:0] KIND_NAN    = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_stall;
  ssmr_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  ssmr_out_t out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  always #(HALF_PERIOD) clk = ~clk;

  scan_sector_min_range_core #(
    .MAX_SAMPLES(SWEEP_CAP),
    .ANGLE_BITS (CFG_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // sample requests waiting for the driver, and summaries still owed by the block
  ssmr_in_t  pending_samples[$];
  ssmr_out_t expected_summaries[$];

  // register copy, follows every write on the config port
  ssmr_cfg_t regs_copy = '{RST_SECTOR_CENTER, RST_SECTOR_HALF_WIDTH, RST_FIRST_ANGLE,
                           RST_ANGLE_STEP, RST_RANGE_FLOOR, RST_RANGE_CEILING,
                           RST_STOP_DISTANCE};

  // sweep tracker state
  bit               sweep_open = 1'b0;
  logic [CFG_W-1:0] beam_ang = '0;
  logic [RANGE_W-1:0] run_min = '1;
  bit               min_unset = 1'b1;
  int               hits = 0;

  int  fail_count = 0;
  int  cycle_count = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  quiet_mode = 1'b0;   // no idling on either side while set
  bit  hold_req = 1'b0;     // asks the receiver for one long hold-off

  // idle length: mostly short, now and then long
  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    else if (r < 93) return $urandom_range(4, 8);
    else return $urandom_range(10, 40);
  endfunction

  function automatic ssmr_in_t make_sample(logic [RANGE_W-1:0] rng, logic [1:0] kind,
                                           logic last);
    ssmr_in_t s;
    s.sample_range_mm = rng;
    s.sample_kind     = kind;
    s.last_sample     = last;
    return s;
  endfunction

  function automatic ssmr_cfg_t make_cfg(int center, int half, int first, int step,
                                         int floor_mm, int ceil_mm, int stop_mm);
    ssmr_cfg_t c;
    c.sector_center     = CFG_W'(center);
    c.sector_half_width = CFG_W'(half);
    c.first_angle       = CFG_W'(first);
    c.angle_step        = CFG_W'(step);
    c.range_floor_mm    = CFG_W'(floor_mm);
    c.range_ceiling_mm  = CFG_W'(ceil_mm);
    c.stop_distance_mm  = CFG_W'(stop_mm);
    return c;
  endfunction

  // advance the tracked sweep by one accepted sample; a last sample owes a summary
  function automatic void track_sweep_sample(ssmr_in_t s);
    logic [CFG_W-1:0] offs;
    logic [CFG_W-1:0] mag;
    bit counted;
    ssmr_out_t res;
    counted = 1'b0;
    if (!sweep_open) begin
      beam_ang   = regs_copy.first_angle;
      sweep_open = 1'b1;
    end
    // signed wrap of the angle difference gives the distance from the center
    offs = beam_ang - regs_copy.sector_center;
    mag  = offs[CFG_W-1] ? (~offs + 16'd1) : offs;
    if (mag <= regs_copy.sector_half_width) begin
      if (s.sample_kind == KIND_POS_INF) begin
        counted = 1'b1;
      end else if (s.sample_kind == KIND_FINITE &&
                   s.sample_range_mm >= regs_copy.range_floor_mm &&
                   s.sample_range_mm <= regs_copy.range_ceiling_mm) begin
        if (min_unset || s.sample_range_mm < run_min) run_min = s.sample_range_mm;
        min_unset = 1'b0;
        counted   = 1'b1;
      end
    end
    if (counted && hits < SWEEP_CAP) hits++;
    beam_ang = beam_ang + regs_copy.angle_step;
    if (s.last_sample) begin
      if (regs_copy.angle_step == '0 ||
          regs_copy.range_ceiling_mm <= regs_copy.range_floor_mm) begin
        // bad metadata throws the sweep away
        res = '0;
        res.min_is_infinite  = 1'b1;
        res.sector_empty     = 1'b1;
        res.metadata_invalid = 1'b1;
      end else begin
        res.min_range_mm     = min_unset ? '0 : run_min;
        res.min_is_infinite  = min_unset;
        res.valid_count      = VCOUNT_W'(hits);
        res.sector_empty     = (hits == 0);
        res.obstacle         = !min_unset && run_min <= regs_copy.stop_distance_mm;
        res.metadata_invalid = 1'b0;
      end
      expected_summaries.push_back(res);
      sweep_open = 1'b0;
      beam_ang   = '0;
      run_min    = '1;
      min_unset  = 1'b1;
      hits       = 0;
    end
  endfunction

  function automatic void check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
      fail_count++;
    end
  endfunction

  // range content biased toward the current floor, ceiling and stop distance
  function automatic ssmr_in_t random_sample(logic last);
    int unsigned r;
    int lo;
    int hi;
    logic [RANGE_W-1:0] rng;
    logic [1:0] kind;
    lo = regs_copy.range_floor_mm;
    hi = regs_copy.range_ceiling_mm;
    r  = $urandom_range(0, 99);
    if (r < 25) begin
      rng = RANGE_W'($urandom);
    end else if (r < 70) begin
      rng = (hi >= lo) ? RANGE_W'($urandom_range(lo, hi)) : RANGE_W'($urandom);
    end else if (r < 85) begin
      case ($urandom_range(0, 3))
        0:       rng = RANGE_W'(lo - 1);
        1:       rng = RANGE_W'(lo);
        2:       rng = RANGE_W'(hi);
        default: rng = RANGE_W'(hi + 1);
      endcase
    end else begin
      rng = RANGE_W'(int'(regs_copy.stop_distance_mm) + $urandom_range(0, 4) - 2);
    end
    r = $urandom_range(0, 99);
    if (r < 82) kind = KIND_FINITE;
    else if (r < 92) kind = KIND_POS_INF;
    else if (r < 97) kind = KIND_NAN;
    else kind = KIND_UNUSED;
    return make_sample(rng, kind, last);
  endfunction

  function automatic ssmr_cfg_t random_cfg();
    ssmr_cfg_t c;
    int unsigned r;
    int flr;
    int ceil_mm;
    c.sector_center = CFG_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 10) c.sector_half_width = 16'd32768;
    else if (r < 15) c.sector_half_width = '0;
    else if (r < 50) c.sector_half_width = CFG_W'($urandom_range(0, 32768));
    else c.sector_half_width = CFG_W'($urandom_range(1, 6000));
    // first angle often just ahead of the sector so sweeps run through it
    if ($urandom_range(0, 1) == 1) c.first_angle = CFG_W'($urandom);
    else c.first_angle = c.sector_center - CFG_W'($urandom_range(0, 3000));
    r = $urandom_range(0, 99);
    if (r < 5) c.angle_step = '0;
    else if (r < 60) c.angle_step = CFG_W'($urandom_range(1, 800));
    else c.angle_step = CFG_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 10) flr = 0;
    else if (r < 15) flr = 65535;
    else flr = $urandom_range(0, 3000);
    r = $urandom_range(0, 99);
    if (r < 8) ceil_mm = flr;
    else if (r < 13) ceil_mm = (flr > 0) ? $urandom_range(0, flr - 1) : 0;
    else if (r < 25) ceil_mm = 65535;
    else ceil_mm = flr + $urandom_range(1, 15000);
    if (ceil_mm > 65535) ceil_mm = 65535;
    c.range_floor_mm   = CFG_W'(flr);
    c.range_ceiling_mm = CFG_W'(ceil_mm);
    r = $urandom_range(0, 99);
    if (r < 10) c.stop_distance_mm = 16'd1;
    else if (r < 20) c.stop_distance_mm = 16'd65535;
    else c.stop_distance_mm = CFG_W'($urandom_range(1, 5000));
    return c;
  endfunction

  // one register write lands at the next rising edge; cfg_we stays up across a burst
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_SECTOR_CENTER:     regs_copy.sector_center     = val;
      REG_SECTOR_HALF_WIDTH: regs_copy.sector_half_width = val;
      REG_FIRST_ANGLE:       regs_copy.first_angle       = val;
      REG_ANGLE_STEP:        regs_copy.angle_step        = val;
      REG_RANGE_FLOOR:       regs_copy.range_floor_mm    = val;
      REG_RANGE_CEILING:     regs_copy.range_ceiling_mm  = val;
      REG_STOP_DISTANCE:     regs_copy.stop_distance_mm  = val;
      default: ;  // index past the register list is dropped by the block
    endcase
  endtask

  task automatic program_regs(input ssmr_cfg_t c, input bit poke_unused);
    write_reg(REG_SECTOR_CENTER,     c.sector_center);
    write_reg(REG_SECTOR_HALF_WIDTH, c.sector_half_width);
    write_reg(REG_FIRST_ANGLE,       c.first_angle);
    write_reg(REG_ANGLE_STEP,        c.angle_step);
    write_reg(REG_RANGE_FLOOR,       c.range_floor_mm);
    write_reg(REG_RANGE_CEILING,     c.range_ceiling_mm);
    write_reg(REG_STOP_DISTANCE,     c.stop_distance_mm);
    if (poke_unused) write_reg(REG_UNUSED, CFG_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // block idle: every request taken, every summary back, pipeline drained
  task automatic settle();
    do @(posedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_summaries.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_sweep(input int len, input bit closed);
    for (int i = 0; i < len; i++)
      pending_samples.push_back(random_sample(closed && i == len - 1));
  endtask

  // driver: takes the next request from the queue once the current one is accepted
  always @(posedge clk) begin
    bit fire;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      fire = in_valid && !in_stall;
      if (fire) track_sweep_sample(in_data);
      if (!in_valid || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          in_data  <= pending_samples.pop_front();
          in_valid <= 1'b1;
          gap_left = (quiet_mode || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted summary and drives the receiver stall
  always @(posedge clk) begin
    ssmr_out_t want;
    bit stall_next;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_summaries.size() == 0) begin
          $display("%0t: unexpected summary: expected none, actual %h", $time, out_data);
          fail_count++;
        end else begin
          want = expected_summaries.pop_front();
          check_field("min_range_mm", want.min_range_mm, out_data.min_range_mm);
          check_field("min_is_infinite", want.min_is_infinite, out_data.min_is_infinite);
          check_field("valid_count", want.valid_count, out_data.valid_count);
          check_field("sector_empty", want.sector_empty, out_data.sector_empty);
          check_field("obstacle", want.obstacle, out_data.obstacle);
          check_field("metadata_invalid", want.metadata_invalid,
                      out_data.metadata_invalid);
        end
      end
      // long hold-off so the result register backs up into the input side
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req   = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else if (!quiet_mode && $urandom_range(0, 99) < 20) begin
        stall_left = idle_len() - 1;
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall <= stall_next;
    end
  end

  // runaway guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("scan_sector_min_range_core verification failed");
      $finish;
    end
  end

  initial begin
    ssmr_cfg_t c;
    int made;
    int budget;
    int len;
    int phase;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: first angles sit opposite the sector center, sweep is empty
    pending_samples.push_back(make_sample(16'd500, KIND_FINITE, 1'b0));
    pending_samples.push_back(make_sample(16'd0, KIND_POS_INF, 1'b0));
    pending_samples.push_back(make_sample(16'd600, KIND_FINITE, 1'b1));
    settle();

    // every sample kind and the range bounds, all inside a narrow sector;
    // also a write past the register list
    program_regs(make_cfg(0, 1000, 0, 100, 150, 12000, 600), 1'b1);
    pending_samples.push_back(make_sample(16'd149, KIND_FINITE, 1'b0));
    pending_samples.push_back(make_sample(16'd150, KIND_FINITE, 1'b0));
    pending_samples.push_back(make_sample(16'd12001, KIND_FINITE, 1'b0));
    pending_samples.push_back(make_sample(16'd12000, KIND_FINITE, 1'b0));
    pending_samples.push_back(make_sample(16'd10, KIND_NAN, 1'b0));
    pending_samples.push_back(make_sample(16'd300, KIND_UNUSED, 1'b0));
    pending_samples.push_back(make_sample(16'd0, KIND_POS_INF, 1'b0));
    pending_samples.push_back(make_sample(16'd700, KIND_FINITE, 1'b0));
    pending_samples.push_back(make_sample(16'd0, KIND_FINITE, 1'b0));
    pending_samples.push_back(make_sample(16'hFFFF, KIND_FINITE, 1'b0));
    pending_samples.push_back(make_sample(16'd400, KIND_FINITE, 1'b1));
    settle();

    // full-scale ranges, whole circle, largest step and stop distance;
    // a sweep of only infinity, and a zero range
    program_regs(make_cfg(0, 32768, 65535, 65535, 0, 65535, 65535), 1'b0);
    pending_samples.push_back(make_sample(16'hFFFF, KIND_FINITE, 1'b0));
    pending_samples.push_back(make_sample(16'd0, KIND_POS_INF, 1'b1));
    pending_samples.push_back(make_sample(16'd5, KIND_POS_INF, 1'b1));
    pending_samples.push_back(make_sample(16'd0, KIND_FINITE, 1'b1));
    settle();

    // half-turn distance: just outside with half width one short of it
    program_regs(make_cfg(0, 32767, 32768, 1, 0, 65535, 1), 1'b0);
    pending_samples.push_back(make_sample(16'd300, KIND_FINITE, 1'b0));
    pending_samples.push_back(make_sample(16'd400, KIND_FINITE, 1'b1));
    settle();
    // and inside once the half width reaches a half turn
    program_regs(make_cfg(0, 32768, 32768, 1, 0, 65535, 1), 1'b0);
    pending_samples.push_back(make_sample(16'd1, KIND_FINITE, 1'b1));
    settle();

    // registers rewritten in the middle of a sweep
    program_regs(make_cfg(0, 32768, 0, 7, 100, 5000, 200), 1'b0);
    pending_samples.push_back(make_sample(16'd250, KIND_FINITE, 1'b0));
    pending_samples.push_back(make_sample(16'd0, KIND_POS_INF, 1'b0));
    settle();
    c = regs_copy;
    c.range_floor_mm    = 16'd300;
    c.first_angle       = 16'd5;
    c.sector_half_width = '0;
    program_regs(c, 1'b0);
    pending_samples.push_back(make_sample(16'd320, KIND_FINITE, 1'b1));
    settle();

    // bad metadata: zero step, then ceiling equal to floor
    program_regs(make_cfg(0, 32768, 0, 0, 100, 5000, 600), 1'b0);
    pending_samples.push_back(make_sample(16'd500, KIND_FINITE, 1'b1));
    settle();
    program_regs(make_cfg(0, 32768, 0, 1, 800, 800, 600), 1'b0);
    pending_samples.push_back(make_sample(16'd800, KIND_FINITE, 1'b0));
    pending_samples.push_back(make_sample(16'd800, KIND_FINITE, 1'b1));
    settle();

    // random phases: fresh registers each time, mostly closed sweeps of random
    // length, some left open to run into the next phase
    made  = 0;
    phase = 0;
    while (made < RANDOM_ITEMS) begin
      if (phase > 0) settle();
      program_regs(random_cfg(), $urandom_range(0, 3) == 0);
      quiet_mode = ($urandom_range(0, 3) == 0) && phase != 2;
      if (phase == 2) hold_req = 1'b1;
      budget = $urandom_range(40, 110);
      while (budget > 0) begin
        if (phase == 2) len = $urandom_range(1, 3);
        else if ($urandom_range(0, 9) == 0) len = 1;
        else if ($urandom_range(0, 6) != 0) len = $urandom_range(2, 12);
        else len = $urandom_range(13, 40);
        if (len > budget) len = budget;
        queue_sweep(len, $urandom_range(0, 9) != 0);
        made   += len;
        budget -= len;
      end
      phase++;
    end
    settle();

    if (fail_count == 0) begin
      $display("scan_sector_min_range_core verification clean");
    end else begin
      $display("scan_sector_min_range_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/ssmr_pkg.sv
hw/rtl/ssmr_accum.sv
hw/rtl/scan_sector_min_range_core.sv
hw/rtl/ssmr_checker.sv
tb/tb_scan_sector_min_range_core.sv
